// File: src/sc2a_pkg.sv
// shared types, codes and scancode tables for the scancode to ascii queue
`timescale 1ns / 1ps
`default_nettype none

package sc2a_pkg;

  localparam int unsigned QueueDepthDefault = 256;
  localparam int unsigned CharW = 7;
  localparam int unsigned CodeW = 8;
  localparam int unsigned NumCodes = 88;
  localparam int unsigned CodeIdxW = $clog2(NumCodes);

  // request kinds
  localparam logic ReqScan = 1'b0;
  localparam logic ReqRead = 1'b1;

  // shift key codes
  localparam logic [CodeW-1:0] CodeLShiftMake  = 8'h2A;
  localparam logic [CodeW-1:0] CodeRShiftMake  = 8'h36;
  localparam logic [CodeW-1:0] CodeLShiftBreak = 8'hAA;
  localparam logic [CodeW-1:0] CodeRShiftBreak = 8'hB6;

  typedef struct packed {
    logic             req_type;
    logic [CodeW-1:0] scancode;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic             char_valid;
    logic             pending;
    logic             dropped;
  } out_item_t;

  // decoder result
  typedef struct packed {
    logic             is_char;
    logic [CharW-1:0] ch;
  } dec_t;

  // queue commands and status
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [CharW-1:0] PlainMap [NumCodes] = '{
    7'h00, 7'h1B,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D,
    7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D,
    7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60,
    7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
    7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30,
    7'h2E,
    7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CharW-1:0] ShiftMap [NumCodes] = '{
    7'h00, 7'h1B,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B,
    7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D,
    7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E,
    7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30,
    7'h2E,
    7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

`default_nettype wire

// File: src/sc2a_decoder.sv
// shift tracking and set 1 scancode to ascii lookup
`timescale 1ns / 1ps
`default_nettype none

module sc2a_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      scan_acc_i,
  input  wire logic [sc2a_pkg::CodeW-1:0] code_i,
  output sc2a_pkg::dec_t                 dec_o
);
  import sc2a_pkg::*;

  logic shift_q, shift_d;
  logic is_make, is_break, in_table;
  logic [CodeIdxW-1:0] idx;
  logic [CharW-1:0] ch;

  assign is_make  = (code_i == CodeLShiftMake) || (code_i == CodeRShiftMake);
  assign is_break = (code_i == CodeLShiftBreak) || (code_i == CodeRShiftBreak);
  // break codes all sit at 128 and above, so the range check covers them
  assign in_table = (code_i < CodeW'(NumCodes));
  assign idx      = code_i[CodeIdxW-1:0];

  always_comb begin
    ch = '0;
    if (in_table) begin
      ch = shift_q ? ShiftMap[idx] : PlainMap[idx];
    end
  end

  always_comb begin
    shift_d = shift_q;
    if (scan_acc_i && is_make) begin
      shift_d = 1'b1;
    end else if (scan_acc_i && is_break) begin
      shift_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
    end else begin
      shift_q <= shift_d;
    end
  end

  assign dec_o.is_char = !is_make && !is_break && (ch != '0);
  assign dec_o.ch      = ch;

endmodule

`default_nettype wire

// File: src/sc2a_queue.sv
// character ring queue in a synchronous memory with read and write pointers
`timescale 1ns / 1ps
`default_nettype none

module sc2a_queue #(
  parameter int unsigned QueueDepth = sc2a_pkg::QueueDepthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sc2a_pkg::q_cmd_t          cmd_i,
  input  wire logic [sc2a_pkg::CharW-1:0] wr_data_i,
  output logic [sc2a_pkg::CharW-1:0]     rd_data_o,
  output sc2a_pkg::q_stat_t              stat_o
);
  import sc2a_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW-1:0] LastPos = PtrW'(QueueDepth - 1);

  logic [CharW-1:0] mem [QueueDepth];
  logic [CharW-1:0] rd_data_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_next, rd_next;

  assign wr_next = (wr_ptr_q == LastPos) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == LastPos) ? '0 : rd_ptr_q + 1'b1;

  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  // one slot stays free so full and empty differ
  assign stat_o.full  = (wr_next == rd_ptr_q);

  assign wr_ptr_d = cmd_i.push ? wr_next : wr_ptr_q;
  assign rd_ptr_d = cmd_i.pop ? rd_next : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign rd_data_o = rd_data_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cmd_i.pop) |=> !stat_o.empty)
    else $error("queue empty after push");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && !cmd_i.push) |=> !stat_o.full)
    else $error("queue full after pop");

endmodule

`default_nettype wire

// File: src/scancode_to_ascii_fifo_unit.sv
// top level: set 1 scancode decoder feeding a character queue
// usage:
//   input channel in_valid_i/in_ready_o carries in_item_i. req_type = 0 hands
//   over one scancode byte, req_type = 1 asks for the oldest queued character.
//   output channel out_valid_o/out_ready_i carries exactly one out_item_o per
//   input transaction, in order. pending reports a non-empty queue after the
//   transaction; dropped flags a decoded character lost to a full queue.
// result path:
//   a scancode transaction's result goes straight into the output register and
//   is shown in the cycle after acceptance; the next input is taken as that
//   register is emptied. a read transaction first waits in StRead for the
//   registered queue memory read, taking no new input, then fills that register.
//   the queue holds QueueDepth - 1 characters.
// reset:
//   pointers and shift state clear, queue empty, no result pending. the queue
//   memory needs no clearing since only written entries are ever read.
// stall:
//   a single output register holds the result; input is taken only when no
//   read is waiting on memory and that register is empty or being emptied
//   in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_fifo_unit #(
  parameter int unsigned QueueDepth = sc2a_pkg::QueueDepthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire sc2a_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output sc2a_pkg::out_item_t out_item_o
);
  import sc2a_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic      state_q, state_d;
  logic      hit_q, hit_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic      in_acc, is_read, scan_acc;
  dec_t      dec;
  q_cmd_t    qcmd;
  q_stat_t   qstat;
  logic [CharW-1:0] rd_data;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_read    = (in_item_i.req_type == ReqRead);
  assign scan_acc   = in_acc && !is_read;

  sc2a_decoder u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_acc_i (scan_acc),
    .code_i     (in_item_i.scancode),
    .dec_o      (dec)
  );

  assign qcmd.push = scan_acc && dec.is_char && !qstat.full;
  assign qcmd.pop  = in_acc && is_read && !qstat.empty;

  sc2a_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (qcmd),
    .wr_data_i (dec.ch),
    .rd_data_o (rd_data),
    .stat_o    (qstat)
  );

  always_comb begin
    state_d     = state_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      StIdle: begin
        if (scan_acc) begin
          out_valid_d           = 1'b1;
          out_item_d.char_out   = '0;
          out_item_d.char_valid = 1'b0;
          out_item_d.pending    = qcmd.push || !qstat.empty;
          out_item_d.dropped    = dec.is_char && qstat.full;
        end else if (in_acc) begin
          state_d = StRead;
          hit_d   = qcmd.pop;
        end
      end
      StRead: begin
        // pointers already moved, memory data now registered
        out_valid_d           = 1'b1;
        out_item_d.char_out   = hit_q ? rd_data : '0;
        out_item_d.char_valid = hit_q;
        out_item_d.pending    = !qstat.empty;
        out_item_d.dropped    = 1'b0;
        state_d               = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |=> (out_valid_q && (state_q == StIdle)))
    else $error("read transaction gave no result");

  a_read_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=> (state_q == StRead))
    else $error("read transaction skipped memory wait");

  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_acc |=> (out_valid_q && !out_item_q.char_valid))
    else $error("scancode transaction gave no result");

endmodule

`default_nettype wire

// File: tb/sv/scancode_to_ascii_fifo_unit_tb.sv
// testbench for the scancode to ascii queue: directed and random keystrokes checked against a predictor
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_unit_tb;
  import sc2a_pkg::*;

  localparam int unsigned QueueHolds = QueueDepthDefault - 1;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned LongHold = 600;
  localparam int unsigned HoldAtResult = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  // stimulus and scoreboard state
  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int unsigned total_items = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned idle_cycles = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  // predictor state
  logic [CharW-1:0] held_chars[$];
  logic shift_state = 1'b0;

  scancode_to_ascii_fifo_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o(out_item)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // us layout, set 1; each row but the keypad holds the plain keys followed by the shifted ones
  function automatic logic [CharW-1:0] key_char(logic [CodeW-1:0] code, logic shifted);
    string row;
    int base;
    int span;
    row = "";
    base = 0;
    span = 0;
    if (code >= 2 && code <= 13) begin
      row = "1234567890-=!@#$%^&*()_+";
      base = 2;
      span = 12;
    end else if (code >= 16 && code <= 27) begin
      row = "qwertyuiop[]QWERTYUIOP{}";
      base = 16;
      span = 12;
    end else if (code >= 30 && code <= 41) begin
      row = "asdfghjkl;'`ASDFGHJKL:\"~";
      base = 30;
      span = 12;
    end else if (code >= 44 && code <= 53) begin
      row = "zxcvbnm,./ZXCVBNM<>?";
      base = 44;
      span = 10;
    end else if (code >= 71 && code <= 83) begin
      // keypad ignores shift
      row = "789-456+1230.";
      base = 71;
    end
    if (row.len() != 0)
      return CharW'(row.getc(int'(code) - base + (shifted ? span : 0)));
    case (code)
      8'd1:    return 7'h1B;
      8'd14:   return 7'h08;
      8'd15:   return 7'h09;
      8'd28:   return 7'h0A;
      8'd43:   return shifted ? 7'h7C : 7'h5C;
      8'd55:   return 7'h2A;
      8'd57:   return 7'h20;
      default: return 7'h00;
    endcase
  endfunction

  function automatic out_item_t apply_keystroke(in_item_t it);
    out_item_t r;
    logic [CharW-1:0] ch;
    r = '0;
    if (it.req_type == ReqRead) begin
      if (held_chars.size() != 0) begin
        r.char_out = held_chars.pop_front();
        r.char_valid = 1'b1;
      end
    end else if (it.scancode == CodeLShiftMake || it.scancode == CodeRShiftMake) begin
      shift_state = 1'b1;
    end else if (it.scancode == CodeLShiftBreak || it.scancode == CodeRShiftBreak) begin
      shift_state = 1'b0;
    end else if (!it.scancode[CodeW-1]) begin
      ch = key_char(it.scancode, shift_state);
      if (ch != 0) begin
        if (held_chars.size() == QueueHolds) r.dropped = 1'b1;
        else held_chars.push_back(ch);
      end
    end
    r.pending = (held_chars.size() != 0);
    return r;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with no transaction outstanding: %p", got);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    if (got.char_out !== want.char_out) begin
      $error("char_out expected %0h got %0h", want.char_out, got.char_out);
      failures++;
    end
    if (got.char_valid !== want.char_valid) begin
      $error("char_valid expected %0b got %0b", want.char_valid, got.char_valid);
      failures++;
    end
    if (got.pending !== want.pending) begin
      $error("pending expected %0b got %0b", want.pending, got.pending);
      failures++;
    end
    if (got.dropped !== want.dropped) begin
      $error("dropped expected %0b got %0b", want.dropped, got.dropped);
      failures++;
    end
  endtask

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic add_scan(logic [CodeW-1:0] code);
    in_item_t it;
    it.req_type = ReqScan;
    it.scancode = code;
    pending_items.push_back(it);
  endtask

  task automatic add_read(logic [CodeW-1:0] junk);
    in_item_t it;
    it.req_type = ReqRead;
    it.scancode = junk;
    pending_items.push_back(it);
  endtask

  // a burst of typing, optionally under shift
  task automatic add_typing(int unsigned n);
    bit shifted;
    shifted = $urandom_range(0, 2) == 0;
    if (shifted) add_scan($urandom_range(0, 1) ? CodeLShiftMake : CodeRShiftMake);
    repeat (n) add_scan(CodeW'($urandom_range(0, NumCodes - 1)));
    if (shifted && $urandom_range(0, 3) != 0)
      add_scan($urandom_range(0, 1) ? CodeLShiftBreak : CodeRShiftBreak);
  endtask

  // sender: presents queued transactions with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_wait <= 0;
      items_accepted <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_keystroke(in_item));
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
          send_wait <= draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls at random, once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned hold;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      results_seen <= 0;
    end else begin
      hold = recv_wait;
      if (out_valid && out_ready) begin
        check_result(out_item);
        results_seen <= results_seen + 1;
        if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
        hold = (results_seen + 1 == HoldAtResult) ? LongHold : draw_wait(recv_calm);
      end else if (hold != 0) begin
        hold = hold - 1;
      end
      recv_wait <= hold;
      out_ready <= (hold == 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni && idle_cycles + 1 >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned mark;

    // empty read, with every scancode bit set on the ignored field
    add_read(8'hFF);
    // zero table entries, first and last table codes, beyond the table, breaks
    add_scan(8'h00);
    add_scan(8'h01);
    add_scan(8'h57);
    add_scan(8'h58);
    add_scan(8'h7F);
    add_scan(8'hFF);
    add_scan(8'h81);
    add_scan(8'h02);
    // shifted lookups through both shift keys
    add_scan(CodeLShiftMake);
    add_scan(8'h10);
    add_scan(8'h35);
    add_scan(CodeLShiftBreak);
    add_scan(CodeRShiftMake);
    add_scan(8'h1E);
    add_scan(8'h2B);
    add_scan(CodeRShiftBreak);
    add_scan(8'h39);
    add_scan(8'h47);
    // read back all but one of the queued characters
    repeat (7) add_read(8'h00);

    // mixed typing and reading
    mark = pending_items.size();
    while (pending_items.size() < mark + 520) begin
      case ($urandom_range(0, 9))
        0:          add_scan(CodeW'($urandom_range(0, 255)));
        1, 2, 3, 4: repeat ($urandom_range(1, 3)) add_read(CodeW'($urandom_range(0, 255)));
        default:    add_typing($urandom_range(1, 3));
      endcase
    end

    // heavy typing with rare reads to overflow the queue
    mark = pending_items.size();
    while (pending_items.size() < mark + 360) begin
      case ($urandom_range(0, 19))
        0:       add_read(CodeW'($urandom_range(0, 255)));
        1:       add_scan(CodeW'($urandom_range(0, 255)));
        default: add_typing($urandom_range(2, 8));
      endcase
    end

    // drain, with some typing and reads of an empty queue at the end
    mark = pending_items.size();
    while (pending_items.size() < mark + 320) begin
      case ($urandom_range(0, 9))
        0:       add_typing($urandom_range(1, 2));
        default: add_read(CodeW'($urandom_range(0, 255)));
      endcase
    end
    repeat (8) add_read(CodeW'($urandom_range(0, 255)));

    total_items = pending_items.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < total_items || results_seen < total_items) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/sc2a_pkg.sv
src/sc2a_decoder.sv
src/sc2a_queue.sv
src/scancode_to_ascii_fifo_unit.sv
tb/sv/scancode_to_ascii_fifo_unit_tb.sv
